>>> sv/clipped_alpha_rect_fill_macros.svh
// Assertion macros for the rectangle fill engine.
// Included by the top level; expects signals clk and rst in scope.
`ifndef CLIPPED_ALPHA_RECT_FILL_MACROS_SVH
`define CLIPPED_ALPHA_RECT_FILL_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CARF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fill engine check failed");

// Next-cycle implication, ignored while reset is high.
`define CARF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fill engine sequencing check failed");

`endif

>>> sv/carf_pkg.sv
// Package for the clipped alpha rectangle fill engine.
// Holds register indexes, reset values, parameter defaults and the blend math.
package carf_pkg;

  localparam int unsigned MAX_DIM_DEFAULT   = 4096;
  localparam int unsigned ADDR_BITS_DEFAULT = 24;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned REG_W       = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_RECT_WIDTH   = 3'd2,
    REG_RECT_HEIGHT  = 3'd3,
    REG_FILL_RGBA    = 3'd4,
    REG_CLIP_X_LIMIT = 3'd5,
    REG_CLIP_Y_LIMIT = 3'd6,
    REG_LINE_PITCH   = 3'd7
  } cfg_reg_t;

  localparam logic [REG_W-1:0] ORIGIN_RESET = 13'd0;
  localparam logic [REG_W-1:0] DIM_RESET    = 13'd1;
  localparam logic [REG_W-1:0] CLIP_RESET   = 13'd4096;
  localparam logic [REG_W-1:0] PITCH_RESET  = 13'd4096;
  localparam logic [31:0]      FILL_RESET   = 32'd0;

  // Exact floor(n / 255) for n up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
    return s[15:8];
  endfunction

  // (bg * (255 - a) + src * a) / 255, truncated.
  function automatic logic [7:0] blend(input logic [7:0] bg, input logic [7:0] src,
                                       input logic [7:0] a);
    logic [15:0] n;
    n = (16'(bg) * 16'(8'd255 - a)) + (16'(src) * 16'(a));
    return div255(n);
  endfunction

endpackage

>>> sv/clipped_alpha_rect_fill.sv
// Channel  | direction | signals                                | request
// ---------+-----------+----------------------------------------+------------------------
// in       | to block  | in_valid, in_stall, bg_red/green/blue  | one background pixel
// out      | from block| out_valid, out_stall, pixel_address,   | one blended pixel
//          |           | out_red/green/blue, write_enable, last |
// cfg      | to block  | cfg_write, cfg_index, cfg_data         | one register write
//
// One pixel is accepted per clock while in_stall is low; each request passes both stages.
// The first stage registers the pixel with its position, clip and end flags from the
// row and column counters; the second does the address multiply and the three blends.
// Reset (synchronous) clears the counters, the stage valids and loads register defaults.
// An output stall holds the result stage and, when the input stage is full, the input.
//
// Depends on carf_pkg and clipped_alpha_rect_fill_macros.svh.
`include "clipped_alpha_rect_fill_macros.svh"

module clipped_alpha_rect_fill #(
  parameter int unsigned MAX_DIM   = carf_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned ADDR_BITS = carf_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [carf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [carf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          bg_red,
  input  logic [7:0]                          bg_green,
  input  logic [7:0]                          bg_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ADDR_BITS-1:0]                pixel_address,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                write_enable,
  output logic                                last_pixel
);

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned RW    = carf_pkg::REG_W;
  localparam int unsigned XW    = ((CW > RW) ? CW : RW) + 2;
  localparam int unsigned SUM_W = 2 * RW + 1;
  localparam int unsigned AW    = (SUM_W > ADDR_BITS) ? SUM_W : ADDR_BITS;

  typedef struct packed {
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [RW-1:0] x;
    logic [RW-1:0] y;
    logic          we;
    logic          last;
  } stage_t;

  // Configuration registers.
  logic [RW-1:0] origin_x;
  logic [RW-1:0] origin_y;
  logic [RW-1:0] rect_width;
  logic [RW-1:0] rect_height;
  logic [31:0]   fill_rgba;
  logic [RW-1:0] clip_x_limit;
  logic [RW-1:0] clip_y_limit;
  logic [RW-1:0] line_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= carf_pkg::ORIGIN_RESET;
      origin_y     <= carf_pkg::ORIGIN_RESET;
      rect_width   <= carf_pkg::DIM_RESET;
      rect_height  <= carf_pkg::DIM_RESET;
      fill_rgba    <= carf_pkg::FILL_RESET;
      clip_x_limit <= carf_pkg::CLIP_RESET;
      clip_y_limit <= carf_pkg::CLIP_RESET;
      line_pitch   <= carf_pkg::PITCH_RESET;
    end else if (cfg_write) begin
      unique case (carf_pkg::cfg_reg_t'(cfg_index))
        carf_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data[RW-1:0];
        carf_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data[RW-1:0];
        carf_pkg::REG_RECT_WIDTH:   rect_width   <= cfg_data[RW-1:0];
        carf_pkg::REG_RECT_HEIGHT:  rect_height  <= cfg_data[RW-1:0];
        carf_pkg::REG_FILL_RGBA:    fill_rgba    <= cfg_data[31:0];
        carf_pkg::REG_CLIP_X_LIMIT: clip_x_limit <= cfg_data[RW-1:0];
        carf_pkg::REG_CLIP_Y_LIMIT: clip_y_limit <= cfg_data[RW-1:0];
        carf_pkg::REG_LINE_PITCH:   line_pitch   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Last column and row index after clamping the size to 1..MAX_DIM.
  logic [CW-1:0] col_last;
  logic [CW-1:0] row_last;

  always_comb begin
    priority if (rect_width == '0) begin
      col_last = '0;
    end else if (32'(rect_width) > 32'(MAX_DIM)) begin
      col_last = CW'(MAX_DIM - 1);
    end else begin
      col_last = CW'(32'(rect_width) - 32'd1);
    end
    priority if (rect_height == '0) begin
      row_last = '0;
    end else if (32'(rect_height) > 32'(MAX_DIM)) begin
      row_last = CW'(MAX_DIM - 1);
    end else begin
      row_last = CW'(32'(rect_height) - 32'd1);
    end
  end

  // Handshake between the two stages.
  logic   s1_valid;
  logic   s2_valid;
  stage_t s1;
  logic   s2_open;
  logic   in_take;

  assign s2_open  = !s2_valid || !out_stall;
  assign in_stall = s1_valid && !s2_open;
  assign in_take  = in_valid && !in_stall;

  // Position, clip and end flags for the pixel being accepted.
  logic [CW-1:0]        column_count;
  logic [CW-1:0]        row_count;
  logic [CW-1:0]        column_count_next;
  logic [CW-1:0]        row_count_next;
  logic signed [XW-1:0] pos_x;
  logic signed [XW-1:0] pos_y;
  logic                 end_col;
  logic                 end_row;
  logic                 in_clip;
  stage_t               s1_next;

  always_comb begin
    pos_x   = XW'(signed'(origin_x)) + signed'(XW'(column_count));
    pos_y   = XW'(signed'(origin_y)) + signed'(XW'(row_count));
    end_col = column_count >= col_last;
    end_row = row_count >= row_last;
    in_clip = !pos_x[XW-1] && !pos_y[XW-1] &&
              (pos_x < signed'(XW'(clip_x_limit))) &&
              (pos_y < signed'(XW'(clip_y_limit)));

    s1_next.red   = bg_red;
    s1_next.green = bg_green;
    s1_next.blue  = bg_blue;
    s1_next.x     = pos_x[RW-1:0];
    s1_next.y     = pos_y[RW-1:0];
    s1_next.we    = in_clip;
    s1_next.last  = end_col && end_row;

    if (end_col) begin
      column_count_next = '0;
      row_count_next    = end_row ? '0 : row_count + CW'(1);
    end else begin
      column_count_next = column_count + CW'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s2_open) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1 <= s1_next;
    end
  end

  // Result stage: address multiply and the three channel blends.
  logic [SUM_W-1:0]     addr_sum;
  logic [AW-1:0]        addr_wide;
  logic [ADDR_BITS-1:0] pixel_address_next;
  logic                 s2_load;

  assign s2_load   = s1_valid && s2_open;
  assign addr_sum  = SUM_W'(s1.y) * SUM_W'(line_pitch) + SUM_W'(s1.x);
  assign addr_wide = AW'(addr_sum);
  assign pixel_address_next = s1.we ? addr_wide[ADDR_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      pixel_address <= pixel_address_next;
      out_red       <= carf_pkg::blend(s1.red,   fill_rgba[31:24], fill_rgba[7:0]);
      out_green     <= carf_pkg::blend(s1.green, fill_rgba[23:16], fill_rgba[7:0]);
      out_blue      <= carf_pkg::blend(s1.blue,  fill_rgba[15:8],  fill_rgba[7:0]);
      write_enable  <= s1.we;
      last_pixel    <= s1.last;
    end
  end

  assign out_valid = s2_valid;

  // A clipped pixel never carries an address.
  `CARF_ASSERT_NOW(a_clip_addr_zero, out_valid && !write_enable, pixel_address == '0)
  // The input only stalls when the first stage holds a request it cannot pass on.
  `CARF_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid && s2_valid && out_stall)
  // Accepting the final pixel of the rectangle brings both counters back to zero.
  `CARF_ASSERT_NEXT(a_last_wraps, in_take && end_col && end_row,
                    column_count == '0 && row_count == '0)

endmodule
